// ===== src/spimp_pkg.sv =====
// ----------------------------------------------------------------------------
// spimp_pkg: shared types and constants of the SPI master port
// Command classes, configuration layout, status bit positions and sizes.
// ----------------------------------------------------------------------------
package spimp_pkg;

	localparam int FIFO_DEPTH_DEF  = 8;
	localparam int CMD_QUEUE_DEPTH = 4;
	localparam int QPTR_W          = $clog2(CMD_QUEUE_DEPTH);
	localparam int QCNT_W          = $clog2(CMD_QUEUE_DEPTH + 1);

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// bus function codes carried on s_tuser
	typedef enum logic [1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_WRITE  = 2'd1,
		FUNC_READ   = 2'd2,
		FUNC_STATUS = 2'd3
	} func_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_BITS = 3'd0,
		CFG_RATE       = 3'd1,
		CFG_PRESCALE   = 3'd2,
		CFG_CPOL       = 3'd3,
		CFG_CPHA       = 3'd4,
		CFG_ENABLE     = 3'd5,
		CFG_LOOPBACK   = 3'd6
	} cfg_idx_t;

	// status word bit positions
	localparam int STAT_TFE = 0;
	localparam int STAT_TNF = 1;
	localparam int STAT_RNE = 2;
	localparam int STAT_RFF = 3;
	localparam int STAT_BSY = 4;

	localparam logic [3:0] FRAME_BITS_RST = 4'd7;
	localparam logic [3:0] FRAME_BITS_MIN = 4'd3;
	localparam logic [7:0] PRESCALE_RST   = 8'h02;
	localparam logic [7:0] PRESCALE_MASK  = 8'hFE;
	localparam logic [7:0] PRESCALE_MIN   = 8'h02;

	typedef struct packed {
		logic [3:0] frame_bits;
		logic [7:0] rate;
		logic [7:0] prescale;
		logic       cpol;
		logic       cpha;
		logic       enable;
		logic       loopback;
	} cfg_t;

	// classified command passed from front to back
	typedef struct packed {
		logic        tick;
		logic        wr;
		logic        rd;
		logic        stat;
		logic [15:0] word;
		logic        sin;
	} cmd_t;

endpackage

// ===== src/spimp_front.sv =====
// ----------------------------------------------------------------------------
// spimp_front: input stage
// Accepts bus items, decodes the function code and pushes commands.
// ----------------------------------------------------------------------------
module spimp_front
	import spimp_pkg::*;
(
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,   // write_word[15:0], serial_in[16]
	input  logic [1:0]           s_tuser,   // func[1:0]
	input  logic                 q_full,
	output logic                 push,
	output cmd_t                 push_cmd
);

	func_t func;

	assign func     = func_t'(s_tuser);
	assign s_tready = ~q_full;
	assign push     = s_tvalid & ~q_full;

	always_comb begin
		push_cmd      = '0;
		push_cmd.word = s_tdata[15:0];
		push_cmd.sin  = s_tdata[16];
		unique case (func)
			FUNC_TICK:   push_cmd.tick = 1'b1;
			FUNC_WRITE:  push_cmd.wr   = 1'b1;
			FUNC_READ:   push_cmd.rd   = 1'b1;
			FUNC_STATUS: push_cmd.stat = 1'b1;
			default:     push_cmd.tick = 1'b1;
		endcase
	end

endmodule

// ===== src/spimp_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// spimp_cmd_queue: command queue
// Short FIFO that decouples the input stage from the shift engine.
// ----------------------------------------------------------------------------
module spimp_cmd_queue
	import spimp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head_cmd
);

	cmd_t              entry_q [CMD_QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(CMD_QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/spimp_engine.sv =====
// ----------------------------------------------------------------------------
// spimp_engine: shift engine, one command per cycle unless the output stalls
// Per command: FIFO access, bit timing, shifter and result.
// ----------------------------------------------------------------------------
module spimp_engine
	import spimp_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  q_empty,
	input  cmd_t                  cmd,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

	logic [15:0] tx_mem [FIFO_DEPTH];
	logic [15:0] rx_mem [FIFO_DEPTH];

	logic [PTR_W-1:0] tx_head_q, tx_tail_q, rx_head_q, rx_tail_q;
	logic [CNT_W-1:0] tx_fill_q, rx_fill_q;
	logic [15:0]      shift_q, tick_q;
	logic [4:0]       bits_q;
	logic             clk_lvl_q, shifting_q, latch_q;

	logic [PTR_W-1:0] tx_head_d, tx_tail_d, rx_head_d, rx_tail_d;
	logic [CNT_W-1:0] tx_fill_d, rx_fill_d;
	logic [15:0]      shift_d, tick_d;
	logic [4:0]       bits_d;
	logic             clk_lvl_d, shifting_d, latch_d;

	logic             tx_we, rx_we;
	logic [15:0]      rx_wdata;

	logic             out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_DATA_W-1:0] result;

	logic [3:0]  top_idx;
	logic [4:0]  frame_len;
	logic [15:0] frame_mask;
	logic [7:0]  ps_eff;
	logic [15:0] half_period;
	logic [15:0] tick_inc;
	logic        leading, bit_in, finish;
	logic [4:0]  bits_dec;
	logic [15:0] rd_word;
	logic        busy;

	// frame geometry and bit timing from the live configuration
	assign top_idx     = (cfg.frame_bits < FRAME_BITS_MIN) ? FRAME_BITS_MIN : cfg.frame_bits;
	assign frame_len   = {1'b0, top_idx} + 5'd1;
	assign frame_mask  = ~(16'hFFFF << frame_len);
	assign ps_eff      = ((cfg.prescale & PRESCALE_MASK) < PRESCALE_MIN) ? PRESCALE_MIN
	                     : (cfg.prescale & PRESCALE_MASK);
	assign half_period = 16'({9'd0, ps_eff[7:1]} * ({8'd0, cfg.rate} + 16'd1));

	assign pop = ~q_empty & (~out_valid_q | m_tready);

	always_comb begin
		tx_head_d  = tx_head_q;
		tx_tail_d  = tx_tail_q;
		rx_head_d  = rx_head_q;
		rx_tail_d  = rx_tail_q;
		tx_fill_d  = tx_fill_q;
		rx_fill_d  = rx_fill_q;
		shift_d    = shift_q;
		tick_d     = tick_q;
		bits_d     = bits_q;
		clk_lvl_d  = clk_lvl_q;
		shifting_d = shifting_q;
		latch_d    = latch_q;
		tx_we      = 1'b0;
		rx_we      = 1'b0;
		rx_wdata   = '0;
		rd_word    = '0;
		finish     = 1'b0;
		tick_inc   = tick_q + 16'd1;
		leading    = (clk_lvl_q == cfg.cpol);
		bit_in     = cfg.loopback ? shift_q[top_idx] : cmd.sin;
		bits_dec   = (bits_q != '0) ? bits_q - 5'd1 : '0;

		if (cmd.tick && cfg.enable) begin
			if (shifting_q) begin
				if (tick_inc >= half_period) begin
					tick_d    = '0;
					clk_lvl_d = ~clk_lvl_q;
					if (!cfg.cpha) begin
						if (leading) begin
							latch_d = bit_in;
						end else begin
							shift_d = {shift_q[14:0], latch_q} & frame_mask;
							bits_d  = bits_dec;
							finish  = (bits_dec == '0);
						end
					end else begin
						if (leading) begin
							if (bits_q < frame_len) begin
								shift_d = {shift_q[14:0], latch_q} & frame_mask;
							end
						end else begin
							latch_d = bit_in;
							bits_d  = bits_dec;
							if (bits_dec == '0) begin
								shift_d = {shift_q[14:0], bit_in} & frame_mask;
								finish  = 1'b1;
							end
						end
					end
					if (finish) begin
						// hand the received word to the receive FIFO, drop it if full
						rx_we      = (rx_fill_q < FULL_CNT);
						rx_wdata   = shift_d;
						shifting_d = 1'b0;
						clk_lvl_d  = cfg.cpol;
					end
				end else begin
					tick_d = tick_inc;
				end
			end else if (tx_fill_q != '0) begin
				// start a frame from the transmit FIFO head
				shift_d    = tx_mem[tx_head_q] & frame_mask;
				tx_head_d  = (tx_head_q == LAST_PTR) ? '0 : tx_head_q + 1'b1;
				tx_fill_d  = tx_fill_q - 1'b1;
				bits_d     = frame_len;
				tick_d     = '0;
				clk_lvl_d  = cfg.cpol;
				latch_d    = 1'b0;
				shifting_d = 1'b1;
			end
		end

		if (cmd.wr && (tx_fill_q < FULL_CNT)) begin
			tx_we     = 1'b1;
			tx_tail_d = (tx_tail_q == LAST_PTR) ? '0 : tx_tail_q + 1'b1;
			tx_fill_d = tx_fill_q + 1'b1;
		end

		if (rx_we) begin
			rx_tail_d = (rx_tail_q == LAST_PTR) ? '0 : rx_tail_q + 1'b1;
			rx_fill_d = rx_fill_q + 1'b1;
		end

		if (cmd.rd && (rx_fill_q != '0)) begin
			rd_word   = rx_mem[rx_head_q];
			rx_head_d = (rx_head_q == LAST_PTR) ? '0 : rx_head_q + 1'b1;
			rx_fill_d = rx_fill_q - 1'b1;
		end

		busy = shifting_d | (tx_fill_d != '0);
		if (cmd.stat) begin
			rd_word           = '0;
			rd_word[STAT_TFE] = (tx_fill_d == '0);
			rd_word[STAT_TNF] = (tx_fill_d < FULL_CNT);
			rd_word[STAT_RNE] = (rx_fill_d != '0);
			rd_word[STAT_RFF] = (rx_fill_d >= FULL_CNT);
			rd_word[STAT_BSY] = busy;
		end

		result = {4'd0, busy, ~shifting_d,
		          shifting_d & shift_d[top_idx],
		          shifting_d ? clk_lvl_d : cfg.cpol,
		          rd_word};
	end

	always_ff @(posedge clk) begin
		if (pop && tx_we) begin
			tx_mem[tx_tail_q] <= cmd.word;
		end
		if (pop && rx_we) begin
			rx_mem[rx_tail_q] <= rx_wdata;
		end
		if (pop) begin
			out_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q   <= '0;
			tx_tail_q   <= '0;
			rx_head_q   <= '0;
			rx_tail_q   <= '0;
			tx_fill_q   <= '0;
			rx_fill_q   <= '0;
			shift_q     <= '0;
			tick_q      <= '0;
			bits_q      <= '0;
			clk_lvl_q   <= 1'b0;
			shifting_q  <= 1'b0;
			latch_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				tx_head_q  <= tx_head_d;
				tx_tail_q  <= tx_tail_d;
				rx_head_q  <= rx_head_d;
				rx_tail_q  <= rx_tail_d;
				tx_fill_q  <= tx_fill_d;
				rx_fill_q  <= rx_fill_d;
				shift_q    <= shift_d;
				tick_q     <= tick_d;
				bits_q     <= bits_d;
				clk_lvl_q  <= clk_lvl_d;
				shifting_q <= shifting_d;
				latch_q    <= latch_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== src/spi_master_port_with_fifos_top.sv =====
// ----------------------------------------------------------------------------
// spi_master_port_with_fifos_top: SPI master port with transmit/receive FIFOs
// Motorola frame format master; bus ticks and accesses arrive as stream items.
//
//   channel  direction  payload
//   s_*      in         tuser: func; tdata: write_word, serial_in
//   m_*      out        tdata: read_word, serial_clock, serial_out,
//                              frame_select_n, busy_res
//   cfg_*    in         cfg_index selects register, cfg_wdata is its value
//
// One item per cycle sustained while m_* does not stall; each item is registered
// in the command queue and its result in the engine's output register for m_*.
// Reset clears pointers, fill counts, the shifter and all handshake state;
// FIFO contents stay unknown until written.
// A four-entry command queue absorbs output stalls; s_tready drops when it fills.
// ----------------------------------------------------------------------------
module spi_master_port_with_fifos_top
	import spimp_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // write_word[15:0], serial_in[16]
	input  logic [1:0]            s_tuser,   // func[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // read_word[15:0], serial_clock[16],
	                                          // serial_out[17], frame_select_n[18],
	                                          // busy_res[19]
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	logic push, q_full, q_empty, pop;
	cmd_t push_cmd, head_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_bits <= FRAME_BITS_RST;
			cfg_q.rate       <= '0;
			cfg_q.prescale   <= PRESCALE_RST;
			cfg_q.cpol       <= 1'b0;
			cfg_q.cpha       <= 1'b0;
			cfg_q.enable     <= 1'b0;
			cfg_q.loopback   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_BITS: cfg_q.frame_bits <= cfg_wdata[3:0];
				CFG_RATE:       cfg_q.rate       <= cfg_wdata;
				CFG_PRESCALE:   cfg_q.prescale   <= cfg_wdata;
				CFG_CPOL:       cfg_q.cpol       <= cfg_wdata[0];
				CFG_CPHA:       cfg_q.cpha       <= cfg_wdata[0];
				CFG_ENABLE:     cfg_q.enable     <= cfg_wdata[0];
				CFG_LOOPBACK:   cfg_q.loopback   <= cfg_wdata[0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	spimp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	spimp_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head_cmd (head_cmd)
	);

	spimp_engine #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.cmd      (head_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== sim/spi_master_port_with_fifos_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spi_master_port_with_fifos_top_tb: regression bench for the SPI master port
// Drives ticks, data writes, data reads and status reads as stream items.
// Results are checked against typed values or a cycle-free behavioral copy of
// the port (FIFOs, frame shifter, clock edges) in several register settings.
// ----------------------------------------------------------------------------
module spi_master_port_with_fifos_top_tb;
	import spimp_pkg::*;

	localparam int DEPTH        = FIFO_DEPTH_DEF;
	localparam int PTR_W        = $clog2(DEPTH);
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 8;
	localparam int PRINT_LIMIT  = 40;
	localparam int SENDER       = 0;
	localparam int RECEIVER     = 1;

	// field order follows m_tdata from the top bit down
	typedef struct packed {
		logic        busy;
		logic        fsn;
		logic        sout;
		logic        sclk;
		logic [15:0] word;
	} port_res_t;

	typedef struct packed {
		bit          is_cfg;
		cfg_idx_t    idx;
		logic [7:0]  val;
		func_t       fn;
		logic [15:0] w;
		logic        sin;
		bit          typed;
		port_res_t   want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = FUNC_TICK;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_BITS;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int cycle_count = 0;
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int frames_kept = 0;
	int frames_dropped = 0;
	int writes_dropped = 0;
	int calm_left[2] = '{0, 0};

	port_res_t port_results_due[$];
	plan_row_t plan[$];

	// behavioral copy of the port
	cfg_t         port_cfg;
	logic [15:0]  tx_mem[DEPTH];
	logic [15:0]  rx_mem[DEPTH];
	logic [PTR_W:0]   tx_fill, rx_fill;
	logic [PTR_W-1:0] tx_head, rx_head;
	logic [15:0]  shift_word;
	logic [4:0]   bits_left;
	logic [15:0]  tick_count;
	logic         clock_level, shifting, sample_latch;

	spi_master_port_with_fifos_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles, %0d results still due", cycle_count,
			port_results_due.size());
		$display("Regression FAIL");
		$finish;
	end

	function automatic int frame_len();
		int d;
		d = int'(port_cfg.frame_bits);
		if (d < int'(FRAME_BITS_MIN))
			d = int'(FRAME_BITS_MIN);
		return d + 1;
	endfunction

	function automatic logic [15:0] frame_mask();
		return 16'hFFFF >> (16 - frame_len());
	endfunction

	function automatic int half_period();
		int ps;
		ps = int'(port_cfg.prescale & PRESCALE_MASK);
		if (ps < int'(PRESCALE_MIN))
			ps = int'(PRESCALE_MIN);
		return (ps / 2) * (int'(port_cfg.rate) + 1);
	endfunction

	function automatic void close_frame();
		if (rx_fill < DEPTH) begin
			rx_mem[rx_head + PTR_W'(rx_fill)] = shift_word & frame_mask();
			rx_fill++;
			frames_kept++;
		end else begin
			frames_dropped++;
		end
		shifting = 1'b0;
		clock_level = port_cfg.cpol;
		tick_count = '0;
	endfunction

	function automatic void serial_edge(input logic sin);
		int n;
		logic [15:0] m;
		logic leading, bit_in;
		n = frame_len();
		m = frame_mask();
		leading = (clock_level == port_cfg.cpol);
		bit_in = port_cfg.loopback ? shift_word[4'(n - 1)] : sin;
		clock_level = ~clock_level;
		if (!port_cfg.cpha) begin
			// sample on the leading edge, shift on the trailing edge
			if (leading) begin
				sample_latch = bit_in;
			end else begin
				shift_word = ((shift_word << 1) | sample_latch) & m;
				if (bits_left > 0)
					bits_left--;
				if (bits_left == 0)
					close_frame();
			end
		end else begin
			// shift on the leading edge, except before the first bit
			if (leading) begin
				if (bits_left < n)
					shift_word = ((shift_word << 1) | sample_latch) & m;
			end else begin
				sample_latch = bit_in;
				if (bits_left > 0)
					bits_left--;
				if (bits_left == 0) begin
					shift_word = ((shift_word << 1) | sample_latch) & m;
					close_frame();
				end
			end
		end
	endfunction

	function automatic void advance_shifter(input logic sin);
		if (port_cfg.enable) begin
			if (shifting) begin
				tick_count = tick_count + 16'd1;
				if (tick_count >= half_period()) begin
					tick_count = '0;
					serial_edge(sin);
				end
			end else if (tx_fill > 0) begin
				shift_word = tx_mem[tx_head] & frame_mask();
				tx_head = tx_head + 1'b1;
				tx_fill--;
				bits_left = 5'(frame_len());
				tick_count = '0;
				clock_level = port_cfg.cpol;
				sample_latch = 1'b0;
				shifting = 1'b1;
			end
		end
	endfunction

	function automatic port_res_t predict_port_item(input func_t fn, input logic [15:0] w,
			input logic sin);
		port_res_t r;
		r = '0;
		case (fn)
			FUNC_TICK: begin
				advance_shifter(sin);
			end
			FUNC_WRITE: begin
				if (tx_fill < DEPTH) begin
					tx_mem[tx_head + PTR_W'(tx_fill)] = w;
					tx_fill++;
				end else begin
					writes_dropped++;
				end
			end
			FUNC_READ: begin
				if (rx_fill > 0) begin
					r.word = rx_mem[rx_head];
					rx_head = rx_head + 1'b1;
					rx_fill--;
				end
			end
			default: ;
		endcase
		r.busy = shifting || (tx_fill != 0);
		if (fn == FUNC_STATUS) begin
			r.word[STAT_TFE] = (tx_fill == 0);
			r.word[STAT_TNF] = (tx_fill < DEPTH);
			r.word[STAT_RNE] = (rx_fill > 0);
			r.word[STAT_RFF] = (rx_fill >= DEPTH);
			r.word[STAT_BSY] = r.busy;
		end
		r.sclk = shifting ? clock_level : port_cfg.cpol;
		r.sout = shifting ? shift_word[4'(frame_len() - 1)] : 1'b0;
		r.fsn = !shifting;
		return r;
	endfunction

	// idle length for one item; now and then a calm run with no idling at all
	function automatic int draw_idle_cycles(input int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left[side] = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 6);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("[%0t] %s: got 0x%0h, want 0x%0h (result %0d)", $time, what, got, want,
				results_seen);
	endtask

	task automatic send_item(input func_t fn, input logic [15:0] w, input logic sin,
			input bit typed, input port_res_t want);
		int gap;
		port_res_t r;
		gap = draw_idle_cycles(SENDER);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {{(IN_DATA_W-17){1'b0}}, sin, w};
		do @(posedge clk); while (!s_tready);
		r = predict_port_item(fn, w, sin);
		port_results_due.push_back(typed ? want : r);
		items_sent++;
	endtask

	// drop valid and let every due result come back
	task automatic settle();
		s_tvalid <= 1'b0;
		for (int k = 0; k < DRAIN_LIMIT && port_results_due.size() != 0; k++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FRAME_BITS: port_cfg.frame_bits = v[3:0];
			CFG_RATE:       port_cfg.rate = v;
			CFG_PRESCALE:   port_cfg.prescale = v;
			CFG_CPOL:       port_cfg.cpol = v[0];
			CFG_CPHA:       port_cfg.cpha = v[0];
			CFG_ENABLE:     port_cfg.enable = v[0];
			CFG_LOOPBACK:   port_cfg.loopback = v[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [3:0] fb, input logic [7:0] rate, presc,
			input logic cpol, cpha, en, lb, input int count, wt, ww, wr, ws);
		int pick;
		func_t fn;
		logic [15:0] w;
		settle();
		write_reg(CFG_FRAME_BITS, {4'd0, fb});
		write_reg(CFG_RATE, rate);
		write_reg(CFG_PRESCALE, presc);
		write_reg(CFG_CPOL, {7'd0, cpol});
		write_reg(CFG_CPHA, {7'd0, cpha});
		write_reg(CFG_ENABLE, {7'd0, en});
		write_reg(CFG_LOOPBACK, {7'd0, lb});
		repeat (count) begin
			pick = $urandom_range(0, wt + ww + wr + ws - 1);
			if (pick < wt)
				fn = FUNC_TICK;
			else if (pick < wt + ww)
				fn = FUNC_WRITE;
			else if (pick < wt + ww + wr)
				fn = FUNC_READ;
			else
				fn = FUNC_STATUS;
			case ($urandom_range(0, 7))
				0: w = 16'h0000;
				1: w = 16'hFFFF;
				default: w = 16'($urandom_range(0, 16'hFFFF));
			endcase
			send_item(fn, w, 1'($urandom_range(0, 1)), 1'b0, '0);
		end
	endtask

	function automatic void plan_item(input func_t fn, input logic [15:0] w, input logic sin,
			input bit typed = 1'b0, input port_res_t want = '0);
		plan_row_t row;
		row = '0;
		row.fn = fn;
		row.w = w;
		row.sin = sin;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endfunction

	function automatic void plan_cfg(input cfg_idx_t idx, input logic [7:0] v);
		plan_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = v;
		plan.push_back(row);
	endfunction

	initial begin : result_checker
		int stall;
		port_res_t got, want;
		@(posedge arst_n);
		forever begin
			stall = draw_idle_cycles(RECEIVER);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = m_tdata[19:0];
			results_seen++;
			if (port_results_due.size() == 0) begin
				report_mismatch("result with no item pending", got, 0);
			end else begin
				want = port_results_due.pop_front();
				if (got.word !== want.word)
					report_mismatch("read_word", got.word, want.word);
				if (got.sclk !== want.sclk)
					report_mismatch("serial_clock", got.sclk, want.sclk);
				if (got.sout !== want.sout)
					report_mismatch("serial_out", got.sout, want.sout);
				if (got.fsn !== want.fsn)
					report_mismatch("frame_select_n", got.fsn, want.fsn);
				if (got.busy !== want.busy)
					report_mismatch("busy_res", got.busy, want.busy);
			end
		end
	end

	initial begin : stimulus
		port_cfg = '0;
		port_cfg.frame_bits = FRAME_BITS_RST;
		port_cfg.prescale = PRESCALE_RST;
		tx_fill = '0;
		rx_fill = '0;
		tx_head = '0;
		rx_head = '0;
		shift_word = '0;
		bits_left = '0;
		tick_count = '0;
		clock_level = 1'b0;
		shifting = 1'b0;
		sample_latch = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// typed results are {busy, fsn, sout, sclk, word}
		plan_item(FUNC_STATUS, 16'h0000, 1'b0, 1'b1, {4'b0100, 16'h0003});
		plan_item(FUNC_READ, 16'hFFFF, 1'b1, 1'b1, {4'b0100, 16'h0000});
		plan_item(FUNC_TICK, 16'h0000, 1'b1, 1'b1, {4'b0100, 16'h0000});
		plan_item(FUNC_WRITE, 16'hFFFF, 1'b1, 1'b1, {4'b1100, 16'h0000});
		plan_item(FUNC_WRITE, 16'h0000, 1'b0);
		plan_item(FUNC_WRITE, 16'h8001, 1'b1);
		plan_item(FUNC_WRITE, 16'h7FFE, 1'b0);
		plan_item(FUNC_WRITE, 16'hA5A5, 1'b1);
		plan_item(FUNC_WRITE, 16'h5A5A, 1'b0);
		plan_item(FUNC_WRITE, 16'h00FF, 1'b1);
		plan_item(FUNC_WRITE, 16'hFF00, 1'b0);
		// transmit side is full: this one is lost
		plan_item(FUNC_WRITE, 16'hBEEF, 1'b1);
		plan_item(FUNC_STATUS, 16'h0000, 1'b0, 1'b1, {4'b1100, 16'h0010});
		plan_cfg(CFG_LOOPBACK, 8'd1);
		plan_cfg(CFG_ENABLE, 8'd1);
		// frame start loads 0xFF, so the line shows a one at once
		plan_item(FUNC_TICK, 16'h0000, 1'b0, 1'b1, {4'b1010, 16'h0000});
		plan_item(FUNC_TICK, 16'h1111, 1'b1);
		plan_item(FUNC_TICK, 16'h2222, 1'b0);
		plan_item(FUNC_TICK, 16'h4444, 1'b1);
		plan_item(FUNC_TICK, 16'h8888, 1'b0);
		plan_item(FUNC_TICK, 16'hFFFF, 1'b1);
		plan_item(FUNC_READ, 16'h0000, 1'b0);
		plan_item(FUNC_STATUS, 16'h0000, 1'b0);
		// freeze mid-frame, then resume
		plan_cfg(CFG_ENABLE, 8'd0);
		plan_item(FUNC_TICK, 16'h0000, 1'b1);
		plan_item(FUNC_TICK, 16'h0000, 1'b0);
		plan_item(FUNC_STATUS, 16'h0000, 1'b1);
		plan_cfg(CFG_ENABLE, 8'd1);
		plan_item(FUNC_TICK, 16'h0000, 1'b0);
		plan_item(FUNC_WRITE, 16'h0F0F, 1'b1);
		plan_item(FUNC_TICK, 16'h0000, 1'b1);

		foreach (plan[k]) begin
			if (plan[k].is_cfg) begin
				settle();
				write_reg(plan[k].idx, plan[k].val);
			end else begin
				send_item(plan[k].fn, plan[k].w, plan[k].sin, plan[k].typed, plan[k].want);
			end
		end

		//        fb     rate    presc  cpol  cpha  en    lb    items tick wr  rd  stat
		run_phase(4'd7,  8'd0,   8'd2,   1'b0, 1'b0, 1'b1, 1'b1, 100, 70, 15, 10, 5);
		// no reads: let the receive side fill and overflow
		run_phase(4'd3,  8'd0,   8'd2,   1'b1, 1'b1, 1'b1, 1'b0, 140, 75, 20, 0,  5);
		run_phase(4'd15, 8'd1,   8'd3,   1'b0, 1'b1, 1'b1, 1'b1, 100, 55, 15, 25, 5);
		run_phase(4'd0,  8'd0,   8'd254, 1'b1, 1'b0, 1'b0, 1'b0, 40,  40, 40, 10, 10);
		run_phase(4'd1,  8'd0,   8'd0,   1'b1, 1'b0, 1'b1, 1'b0, 100, 70, 15, 10, 5);
		run_phase(4'd15, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1, 40,  60, 20, 10, 10);
		run_phase(4'd8,  8'd2,   8'd2,   1'b0, 1'b0, 1'b1, 1'b0, 110, 75, 15, 5,  5);
		run_phase(4'd12, 8'd0,   8'd1,   1'b1, 1'b0, 1'b1, 1'b1, 100, 75, 10, 10, 5);
		run_phase(4'd7,  8'd0,   8'd2,   1'b0, 1'b1, 1'b1, 1'b0, 100, 55, 10, 30, 5);

		settle();
		if (port_results_due.size() != 0)
			report_mismatch("results never delivered", 0, port_results_due.size());

		$display("Sent %0d items over nine register settings, checked %0d results.",
			items_sent, results_seen);
		$display("Frames received %0d, lost to a full receive side %0d; writes lost %0d.",
			frames_kept, frames_dropped, writes_dropped);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
src/spimp_pkg.sv
src/spimp_front.sv
src/spimp_cmd_queue.sv
src/spimp_engine.sv
src/spi_master_port_with_fifos_top.sv
sim/spi_master_port_with_fifos_top_tb.sv
